@@ src/id3_pkg.sv @@
// Shared types, codes and constants of the ID3v2 tag and frame splitter.
package id3_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int HDR_CNT_W    = 4;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);
  localparam logic [HDR_CNT_W-1:0] TAG_FLAG_POS = 4'd5;
  localparam logic [HDR_CNT_W-1:0] TAG_SIZE_POS = 4'd6;
  localparam logic [HDR_CNT_W-1:0] FRM_SIZE_POS = 4'd4;
  localparam logic [HDR_CNT_W-1:0] FRM_STAT_POS = 4'd8;

  localparam int SIZE_W = 28;
  localparam int ID_W   = 32;
  localparam int KIND_W = 5;

  // Configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_BANNED_A = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BANNED_B = 1'b1;

  // Frame kinds in dispatch order
  localparam logic [KIND_W-1:0] KIND_TEXT      = 5'd0;
  localparam logic [KIND_W-1:0] KIND_URL       = 5'd1;
  localparam logic [KIND_W-1:0] KIND_LIST_BASE = 5'd2;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 5'd22;
  localparam int KIND_LIST_LEN = 20;

  localparam logic [7:0] CH_T = "T";
  localparam logic [7:0] CH_W = "W";

  // Exact ids, kind = KIND_LIST_BASE + position
  localparam logic [ID_W-1:0] KIND_IDS [KIND_LIST_LEN] = '{
    "TXXX", "COMM", "UFID", "RBUF", "MCDI", "RVA2", "POPM", "USLT", "COMR", "ENCR",
    "ETCO", "EQU2", "POSS", "OWNE", "GRID", "PCNT", "USER", "PRIV", "SEEK", "SYLT"
  };

  typedef enum logic [1:0] {
    PH_TAG,
    PH_FRAME,
    PH_BODY,
    PH_PAD
  } phase_t;

  typedef enum logic [2:0] {
    BK_TAG_HDR,
    BK_FRAME_HDR,
    BK_KEPT,
    BK_SKIPPED,
    BK_PAD
  } byte_kind_t;

  // Classifier verdict for the id of the current frame
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              banned;
    logic              id_ok;
  } class_t;

  // One result per input byte
  typedef struct packed {
    logic [2:0]        byte_kind;
    logic [7:0]        byte_out;
    logic [SIZE_W-1:0] tag_size;
    logic [3:0]        tag_flags;
    logic [ID_W-1:0]   frame_id;
    logic [SIZE_W-1:0] frame_size;
    logic [2:0]        status_bits;
    logic [4:0]        format_bits;
    logic [KIND_W-1:0] frame_kind;
    logic              header_done;
    logic              body_last;
  } result_t;

endpackage

@@ src/id3_byte_if.sv @@
// Input byte channel: valid/ready with the raw byte and restart mark.
interface id3_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       tag_start;

  modport source (output valid, output data_byte, output tag_start, input ready);
  modport sink   (input valid, input data_byte, input tag_start, output ready);
endinterface

@@ src/id3_result_if.sv @@
// Result channel: valid/ready with the per-byte classification and descriptor.
interface id3_result_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  byte_kind;
  logic [7:0]                  byte_out;
  logic [id3_pkg::SIZE_W-1:0]  tag_size;
  logic [3:0]                  tag_flags;
  logic [id3_pkg::ID_W-1:0]    frame_id;
  logic [id3_pkg::SIZE_W-1:0]  frame_size;
  logic [2:0]                  status_bits;
  logic [4:0]                  format_bits;
  logic [id3_pkg::KIND_W-1:0]  frame_kind;
  logic                        header_done;
  logic                        body_last;

  modport source (output valid, output byte_kind, output byte_out, output tag_size,
                  output tag_flags, output frame_id, output frame_size,
                  output status_bits, output format_bits, output frame_kind,
                  output header_done, output body_last, input ready);
  modport sink   (input valid, input byte_kind, input byte_out, input tag_size,
                  input tag_flags, input frame_id, input frame_size,
                  input status_bits, input format_bits, input frame_kind,
                  input header_done, input body_last, output ready);
endinterface

@@ src/id3_classify.sv @@
// Frame id classifier: character check, banned-id match and kind dispatch.
module id3_classify (
  input  logic [id3_pkg::ID_W-1:0] frame_id,
  input  logic [id3_pkg::ID_W-1:0] banned_a,
  input  logic [id3_pkg::ID_W-1:0] banned_b,
  output id3_pkg::class_t          verdict
);

  function automatic logic char_ok(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  logic                        all_ok;
  logic                        list_hit;
  logic [id3_pkg::KIND_W-1:0]  list_kind;

  assign all_ok = char_ok(frame_id[31:24]) && char_ok(frame_id[23:16]) &&
                  char_ok(frame_id[15:8])  && char_ok(frame_id[7:0]);

  // Exact-id table lookup; ids are distinct so at most one hits
  always_comb begin
    list_hit  = 1'b0;
    list_kind = id3_pkg::KIND_UNKNOWN;
    for (int i = 0; i < id3_pkg::KIND_LIST_LEN; i++) begin
      if (frame_id == id3_pkg::KIND_IDS[i]) begin
        list_hit  = 1'b1;
        list_kind = id3_pkg::KIND_LIST_BASE + id3_pkg::KIND_W'(i);
      end
    end
  end

  // Dispatch order: bad chars, T*** (not TXXX), W***, table, unknown
  always_comb begin
    verdict.id_ok  = all_ok;
    verdict.banned = (banned_a != '0 && frame_id == banned_a) ||
                     (banned_b != '0 && frame_id == banned_b);
    if (!all_ok)
      verdict.kind = id3_pkg::KIND_UNKNOWN;
    else if (frame_id[31:24] == id3_pkg::CH_T && frame_id != id3_pkg::KIND_IDS[0])
      verdict.kind = id3_pkg::KIND_TEXT;
    else if (frame_id[31:24] == id3_pkg::CH_W)
      verdict.kind = id3_pkg::KIND_URL;
    else if (list_hit)
      verdict.kind = list_kind;
    else
      verdict.kind = id3_pkg::KIND_UNKNOWN;
  end

endmodule

@@ src/id3_parser.sv @@
// Byte-serial parser state: tag header, frame headers, body and padding.
module id3_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     tag_start,
  input  logic [id3_pkg::ID_W-1:0] banned_a,
  input  logic [id3_pkg::ID_W-1:0] banned_b,
  output id3_pkg::result_t         result
);

  id3_pkg::phase_t                 phase, phase_next;
  logic [id3_pkg::HDR_CNT_W-1:0]   header_count, header_count_next;
  logic [id3_pkg::ID_W-1:0]        id_shift, id_shift_next;
  logic [id3_pkg::SIZE_W-1:0]      size_accum, size_accum_next;
  logic [id3_pkg::SIZE_W-1:0]      body_remaining, body_remaining_next;
  logic                            frame_banned, frame_banned_next;
  logic [id3_pkg::SIZE_W-1:0]      tag_size_reg, tag_size_reg_next;
  logic [3:0]                      tag_flag_reg, tag_flag_reg_next;
  logic [7:0]                      frame_flag_reg, frame_flag_reg_next;
  logic [id3_pkg::KIND_W-1:0]      kind_reg, kind_reg_next;

  id3_pkg::phase_t                 cur_phase;
  logic [id3_pkg::HDR_CNT_W-1:0]   cur_count;
  id3_pkg::byte_kind_t             byte_kind;
  logic                            header_done;
  logic                            body_last;
  id3_pkg::class_t                 verdict;

  id3_classify u_classify (
    .frame_id (id_shift),
    .banned_a (banned_a),
    .banned_b (banned_b),
    .verdict  (verdict)
  );

  // Next state for the current byte
  always_comb begin
    cur_phase           = tag_start ? id3_pkg::PH_TAG : phase;
    cur_count           = tag_start ? '0 : header_count;
    phase_next          = cur_phase;
    header_count_next   = cur_count;
    tag_size_reg_next   = tag_start ? '0 : tag_size_reg;
    tag_flag_reg_next   = tag_start ? '0 : tag_flag_reg;
    id_shift_next       = id_shift;
    size_accum_next     = size_accum;
    body_remaining_next = body_remaining;
    frame_banned_next   = frame_banned;
    frame_flag_reg_next = frame_flag_reg;
    kind_reg_next       = kind_reg;
    byte_kind           = id3_pkg::BK_PAD;
    header_done         = 1'b0;
    body_last           = 1'b0;

    unique case (cur_phase)
      id3_pkg::PH_TAG: begin
        byte_kind = id3_pkg::BK_TAG_HDR;
        if (cur_count == id3_pkg::TAG_FLAG_POS)
          tag_flag_reg_next = data_byte[7:4];
        else if (cur_count >= id3_pkg::TAG_SIZE_POS)
          tag_size_reg_next = {tag_size_reg_next[id3_pkg::SIZE_W-8:0], data_byte[6:0]};
        if (cur_count >= id3_pkg::HDR_LAST) begin
          phase_next        = id3_pkg::PH_FRAME;
          header_count_next = '0;
        end else begin
          header_count_next = cur_count + 1'b1;
        end
      end
      id3_pkg::PH_FRAME: begin
        byte_kind = id3_pkg::BK_FRAME_HDR;
        if (cur_count < id3_pkg::FRM_SIZE_POS)
          id_shift_next = {id_shift[23:0], data_byte};
        else if (cur_count < id3_pkg::FRM_STAT_POS)
          size_accum_next = {size_accum[id3_pkg::SIZE_W-8:0], data_byte[6:0]};
        else if (cur_count == id3_pkg::FRM_STAT_POS)
          frame_flag_reg_next[7:5] = data_byte[6:4];
        else
          frame_flag_reg_next[4:0] = {data_byte[6], data_byte[3:0]};
        if (cur_count >= id3_pkg::HDR_LAST) begin
          // Header complete: id and size are settled in the registers
          header_done         = 1'b1;
          header_count_next   = '0;
          kind_reg_next       = verdict.kind;
          frame_banned_next   = verdict.banned;
          body_remaining_next = size_accum;
          if (!verdict.banned && !verdict.id_ok)
            phase_next = id3_pkg::PH_PAD;
          else if (size_accum != '0)
            phase_next = id3_pkg::PH_BODY;
          else
            phase_next = id3_pkg::PH_FRAME;
        end else begin
          header_count_next = cur_count + 1'b1;
        end
      end
      id3_pkg::PH_BODY: begin
        byte_kind = frame_banned ? id3_pkg::BK_SKIPPED : id3_pkg::BK_KEPT;
        if (body_remaining <= id3_pkg::SIZE_W'(1)) begin
          body_last           = 1'b1;
          body_remaining_next = '0;
          phase_next          = id3_pkg::PH_FRAME;
          header_count_next   = '0;
        end else begin
          body_remaining_next = body_remaining - 1'b1;
        end
      end
      id3_pkg::PH_PAD: begin
        byte_kind = id3_pkg::BK_PAD;
      end
    endcase
  end

  // Result shows the registers after this byte
  always_comb begin
    result.byte_kind   = byte_kind;
    result.byte_out    = data_byte;
    result.tag_size    = tag_size_reg_next;
    result.tag_flags   = tag_flag_reg_next;
    result.frame_id    = id_shift_next;
    result.frame_size  = size_accum_next;
    result.status_bits = frame_flag_reg_next[7:5];
    result.format_bits = frame_flag_reg_next[4:0];
    result.frame_kind  = kind_reg_next;
    result.header_done = header_done;
    result.body_last   = body_last;
  end

  // State registers advance only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= id3_pkg::PH_TAG;
      header_count   <= '0;
      id_shift       <= '0;
      size_accum     <= '0;
      body_remaining <= '0;
      frame_banned   <= 1'b0;
      tag_size_reg   <= '0;
      tag_flag_reg   <= '0;
      frame_flag_reg <= '0;
      kind_reg       <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      id_shift       <= id_shift_next;
      size_accum     <= size_accum_next;
      body_remaining <= body_remaining_next;
      frame_banned   <= frame_banned_next;
      tag_size_reg   <= tag_size_reg_next;
      tag_flag_reg   <= tag_flag_reg_next;
      frame_flag_reg <= frame_flag_reg_next;
      kind_reg       <= kind_reg_next;
    end
  end

  // Header counter never runs past the last header byte
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= id3_pkg::HDR_LAST)
    else $error("header counter out of range");

  // Body phase always has bytes left
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == id3_pkg::PH_BODY |-> body_remaining != '0)
    else $error("body phase with nothing remaining");

  // Padding is left only by a restart
  a_pad_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == id3_pkg::PH_PAD && !(accept && tag_start)) |=> phase == id3_pkg::PH_PAD)
    else $error("left padding without restart");

endmodule

@@ src/id3_out_buf.sv @@
// Two-entry output buffer: result register plus skid entry.
module id3_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  id3_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output id3_pkg::result_t out_data
);

  logic             main_valid;
  logic             skid_valid;
  id3_pkg::result_t main_data;
  id3_pkg::result_t skid_data;
  logic             pop;

  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign pop       = main_valid && out_ready;

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // Skid entry only holds data behind a full result register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry without result entry");

  // No request taken while both entries are full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push into full buffer");

  // Draining with a waiting skid entry keeps a result on the output
  a_skid_refill: assert property (@(posedge clk) disable iff (rst)
    (pop && skid_valid) |=> (main_valid && !skid_valid))
    else $error("skid entry lost on drain");

endmodule

@@ src/id3v2_frame_splitter.sv @@
// ID3v2 tag and frame splitter top level: one result per input byte.
// A result is registered in the output buffer when its byte is accepted.
// Throughput: one byte per cycle while the output buffer has space; the parser next state is combinational.
// A two-entry output buffer keeps accepting while a result waits to be taken.
// Reset (synchronous, active high) clears parser state, buffer and banned ids;
// the first byte after reset is taken as tag header byte 0.
module id3v2_frame_splitter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [id3_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [id3_pkg::ID_W-1:0]            wr_data,
  id3_byte_if.sink                            stream,
  id3_result_if.source                        parsed
);

  logic [id3_pkg::ID_W-1:0] banned_a;
  logic [id3_pkg::ID_W-1:0] banned_b;
  logic                     accept;
  logic                     space;
  id3_pkg::result_t         step_result;
  id3_pkg::result_t         out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      banned_a <= '0;
      banned_b <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        id3_pkg::REG_BANNED_A: banned_a <= wr_data;
        id3_pkg::REG_BANNED_B: banned_b <= wr_data;
        default: ;
      endcase
    end
  end

  assign stream.ready = space;
  assign accept       = stream.valid && space;

  id3_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (stream.data_byte),
    .tag_start (stream.tag_start),
    .banned_a  (banned_a),
    .banned_b  (banned_b),
    .result    (step_result)
  );

  id3_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .space     (space),
    .out_valid (parsed.valid),
    .out_ready (parsed.ready),
    .out_data  (out_data)
  );

  // Result channel payload
  assign parsed.byte_kind   = out_data.byte_kind;
  assign parsed.byte_out    = out_data.byte_out;
  assign parsed.tag_size    = out_data.tag_size;
  assign parsed.tag_flags   = out_data.tag_flags;
  assign parsed.frame_id    = out_data.frame_id;
  assign parsed.frame_size  = out_data.frame_size;
  assign parsed.status_bits = out_data.status_bits;
  assign parsed.format_bits = out_data.format_bits;
  assign parsed.frame_kind  = out_data.frame_kind;
  assign parsed.header_done = out_data.header_done;
  assign parsed.body_last   = out_data.body_last;

endmodule

@@ sim/id3v2_frame_splitter_tb.sv @@
// Testbench for the ID3v2 tag and frame splitter: random byte streams checked against a predictor.
`timescale 1ns / 100ps

module id3v2_frame_splitter_tb;

  // One byte request on the input channel
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  // Ids with a fixed kind, kind = KIND_LIST_BASE + position
  localparam logic [31:0] DISPATCH_IDS [20] = '{
    "TXXX", "COMM", "UFID", "RBUF", "MCDI", "RVA2", "POPM", "USLT", "COMR", "ENCR",
    "ETCO", "EQU2", "POSS", "OWNE", "GRID", "PCNT", "USER", "PRIV", "SEEK", "SYLT"
  };

  logic                          clk;
  logic                          rst;
  logic                          wr_en;
  logic [id3_pkg::REG_IDX_W-1:0] wr_index;
  logic [id3_pkg::ID_W-1:0]      wr_data;

  id3_byte_if   byte_ch ();
  id3_result_if res_ch ();

  id3v2_frame_splitter u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .stream   (byte_ch),
    .parsed   (res_ch)
  );

  // Stimulus and expectation stores
  stream_byte_t      pending_bytes[$];
  id3_pkg::result_t  expected_results[$];
  logic              byte_taken;
  logic              steady_run;
  int                gap_left;
  int                stall_left;
  int                mismatch_count;

  // Predictor state
  id3_pkg::phase_t parse_phase;
  logic [3:0]      hdr_pos;
  logic [31:0]     id_word;
  logic [27:0]     size_word;
  logic [27:0]     body_left;
  logic            skip_body;
  logic [27:0]     tag_size_q;
  logic [3:0]      tag_flags_q;
  logic [7:0]      frame_flags_q;
  logic [4:0]      kind_q;
  logic [31:0]     banned_a;
  logic [31:0]     banned_b;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame id helpers
  function automatic logic id_char_ok(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic id_valid(input logic [31:0] id);
    return id_char_ok(id[31:24]) && id_char_ok(id[23:16]) &&
           id_char_ok(id[15:8]) && id_char_ok(id[7:0]);
  endfunction

  function automatic logic [4:0] frame_class(input logic [31:0] id);
    if (!id_valid(id)) return id3_pkg::KIND_UNKNOWN;
    if (id[31:24] == "T" && id != DISPATCH_IDS[0]) return id3_pkg::KIND_TEXT;
    if (id[31:24] == "W") return id3_pkg::KIND_URL;
    for (int i = 0; i < 20; i++) begin
      if (id == DISPATCH_IDS[i]) return id3_pkg::KIND_LIST_BASE + 5'(i);
    end
    return id3_pkg::KIND_UNKNOWN;
  endfunction

  // Predict the result of one accepted byte and advance the parser copy
  task automatic parse_byte(input logic [7:0] b, input logic restart,
                            output id3_pkg::result_t r);
    id3_pkg::byte_kind_t bk;
    logic                hdone;
    logic                blast;
    bk    = id3_pkg::BK_PAD;
    hdone = 1'b0;
    blast = 1'b0;
    if (restart) begin
      parse_phase = id3_pkg::PH_TAG;
      hdr_pos     = '0;
      tag_size_q  = '0;
      tag_flags_q = '0;
    end
    case (parse_phase)
      id3_pkg::PH_TAG: begin
        bk = id3_pkg::BK_TAG_HDR;
        if (hdr_pos == id3_pkg::TAG_FLAG_POS) tag_flags_q = b[7:4];
        else if (hdr_pos >= id3_pkg::TAG_SIZE_POS) tag_size_q = {tag_size_q[20:0], b[6:0]};
        if (hdr_pos >= id3_pkg::HDR_LAST) begin
          parse_phase = id3_pkg::PH_FRAME;
          hdr_pos     = '0;
        end else begin
          hdr_pos++;
        end
      end
      id3_pkg::PH_FRAME: begin
        bk = id3_pkg::BK_FRAME_HDR;
        if (hdr_pos < id3_pkg::FRM_SIZE_POS) id_word = {id_word[23:0], b};
        else if (hdr_pos < id3_pkg::FRM_STAT_POS) size_word = {size_word[20:0], b[6:0]};
        else if (hdr_pos == id3_pkg::FRM_STAT_POS) frame_flags_q[7:5] = b[6:4];
        else frame_flags_q[4:0] = {b[6], b[3:0]};
        if (hdr_pos >= id3_pkg::HDR_LAST) begin
          hdone     = 1'b1;
          hdr_pos   = '0;
          kind_q    = frame_class(id_word);
          skip_body = (banned_a != 0 && id_word == banned_a) ||
                      (banned_b != 0 && id_word == banned_b);
          body_left = size_word;
          // banned ids are skipped even when their characters are bad
          if (!skip_body && !id_valid(id_word)) parse_phase = id3_pkg::PH_PAD;
          else if (body_left != 0) parse_phase = id3_pkg::PH_BODY;
          else parse_phase = id3_pkg::PH_FRAME;
        end else begin
          hdr_pos++;
        end
      end
      id3_pkg::PH_BODY: begin
        bk = skip_body ? id3_pkg::BK_SKIPPED : id3_pkg::BK_KEPT;
        if (body_left <= 1) begin
          blast       = 1'b1;
          body_left   = '0;
          parse_phase = id3_pkg::PH_FRAME;
          hdr_pos     = '0;
        end else begin
          body_left--;
        end
      end
      default: bk = id3_pkg::BK_PAD;
    endcase
    r.byte_kind   = bk;
    r.byte_out    = b;
    r.tag_size    = tag_size_q;
    r.tag_flags   = tag_flags_q;
    r.frame_id    = id_word;
    r.frame_size  = size_word;
    r.status_bits = frame_flags_q[7:5];
    r.format_bits = frame_flags_q[4:0];
    r.frame_kind  = kind_q;
    r.header_done = hdone;
    r.body_last   = blast;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Stream building
  task automatic queue_byte(input logic [7:0] b, input logic start);
    stream_byte_t item;
    item.data  = b;
    item.start = start;
    pending_bytes.insert(pending_bytes.size(), item);
  endtask

  // Sync-safe size, msb byte first, with a random ignored top bit
  task automatic queue_size(input logic [27:0] s);
    for (int i = 3; i >= 0; i--)
      queue_byte({1'($urandom_range(0, 1)), s[7*i +: 7]}, 1'b0);
  endtask

  task automatic queue_tag_header(input logic start, input logic [7:0] flags,
                                  input logic [27:0] s);
    queue_byte("I", start);
    queue_byte("D", 1'b0);
    queue_byte("3", 1'b0);
    queue_byte(8'($urandom), 1'b0);
    queue_byte(8'($urandom), 1'b0);
    queue_byte(flags, 1'b0);
    queue_size(s);
  endtask

  task automatic queue_frame_header(input logic [31:0] id, input logic [27:0] s,
                                    input logic [7:0] status, input logic [7:0] fmt);
    for (int i = 3; i >= 0; i--) queue_byte(id[8*i +: 8], 1'b0);
    queue_size(s);
    queue_byte(status, 1'b0);
    queue_byte(fmt, 1'b0);
  endtask

  task automatic queue_body(input int n);
    repeat (n) queue_byte(8'($urandom), 1'b0);
  endtask

  function automatic logic [7:0] random_id_char();
    int k;
    k = $urandom_range(0, 35);
    return (k < 26) ? 8'("A" + k) : 8'("0" + k - 26);
  endfunction

  function automatic logic [31:0] pick_frame_id();
    logic [31:0] id;
    id = {random_id_char(), random_id_char(), random_id_char(), random_id_char()};
    case ($urandom_range(0, 9))
      0, 1, 2: id = DISPATCH_IDS[$urandom_range(0, 19)];
      3: id[31:24] = "T";
      4: id[31:24] = "W";
      5: if (banned_a != 0) id = banned_a;
      6: if (banned_b != 0) id = banned_b;
      8: id = $urandom;
      9: id[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(91, 255));
      default: id = id; // well-formed but unlisted
    endcase
    return id;
  endfunction

  // One tag: mostly well-formed frames, sometimes noise or a cut-off sequence
  task automatic queue_random_tag();
    int sel;
    int sz;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
      return;
    end
    queue_tag_header(1'b1, 8'($urandom), 28'($urandom));
    repeat ($urandom_range(1, 6)) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        // huge frame, cut short by the next restart
        queue_frame_header(pick_frame_id(), 28'($urandom), 8'($urandom), 8'($urandom));
        queue_body($urandom_range(0, 5));
        return;
      end
      sz = (sel < 14) ? $urandom_range(0, 6) : $urandom_range(7, 40);
      queue_frame_header(pick_frame_id(), 28'(sz), 8'($urandom), 8'($urandom));
      queue_body(sz);
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        // zero id ends parsing, the rest is padding
        queue_frame_header('0, 28'($urandom), 8'($urandom), 8'($urandom));
        queue_body($urandom_range(0, 8));
      end
      2: queue_body($urandom_range(1, 9)); // frame header cut by the restart
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || expected_results.size() != 0 || byte_ch.valid)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic configure_banned(input logic [31:0] a, input logic [31:0] b);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= id3_pkg::REG_BANNED_A;
    wr_data  <= a;
    banned_a  = a;
    @(negedge clk);
    wr_index <= id3_pkg::REG_BANNED_B;
    wr_data  <= b;
    banned_b  = b;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // Input driver: holds a request until taken, random gaps between requests
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (byte_ch.valid && !byte_taken) begin
      // request still waiting
    end else if (gap_left > 0) begin
      gap_left--;
      byte_ch.valid <= 1'b0;
    end else if (pending_bytes.size() != 0 && !steady_run && $urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(0, 14);
      byte_ch.valid <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      byte_ch.valid     <= 1'b1;
      byte_ch.data_byte <= pending_bytes[0].data;
      byte_ch.tag_start <= pending_bytes[0].start;
    end else begin
      byte_ch.valid <= 1'b0;
    end
  end

  // Result sink: random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!steady_run && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Monitor: check results, then predict for the accepted byte
  always @(posedge clk) begin : monitor
    id3_pkg::result_t observed;
    id3_pkg::result_t predicted;
    byte_taken = 1'b0;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        observed = {res_ch.byte_kind, res_ch.byte_out, res_ch.tag_size, res_ch.tag_flags,
                    res_ch.frame_id, res_ch.frame_size, res_ch.status_bits,
                    res_ch.format_bits, res_ch.frame_kind, res_ch.header_done,
                    res_ch.body_last};
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, byte_out",
                          32'(observed.byte_out), '0);
        end else begin
          predicted = expected_results.pop_front();
          if (observed.byte_kind !== predicted.byte_kind)
            report_mismatch("byte_kind", 32'(observed.byte_kind), 32'(predicted.byte_kind));
          if (observed.byte_out !== predicted.byte_out)
            report_mismatch("byte_out", 32'(observed.byte_out), 32'(predicted.byte_out));
          if (observed.tag_size !== predicted.tag_size)
            report_mismatch("tag_size", 32'(observed.tag_size), 32'(predicted.tag_size));
          if (observed.tag_flags !== predicted.tag_flags)
            report_mismatch("tag_flags", 32'(observed.tag_flags), 32'(predicted.tag_flags));
          if (observed.frame_id !== predicted.frame_id)
            report_mismatch("frame_id", observed.frame_id, predicted.frame_id);
          if (observed.frame_size !== predicted.frame_size)
            report_mismatch("frame_size", 32'(observed.frame_size),
                            32'(predicted.frame_size));
          if (observed.status_bits !== predicted.status_bits)
            report_mismatch("status_bits", 32'(observed.status_bits),
                            32'(predicted.status_bits));
          if (observed.format_bits !== predicted.format_bits)
            report_mismatch("format_bits", 32'(observed.format_bits),
                            32'(predicted.format_bits));
          if (observed.frame_kind !== predicted.frame_kind)
            report_mismatch("frame_kind", 32'(observed.frame_kind),
                            32'(predicted.frame_kind));
          if (observed.header_done !== predicted.header_done)
            report_mismatch("header_done", 32'(observed.header_done),
                            32'(predicted.header_done));
          if (observed.body_last !== predicted.body_last)
            report_mismatch("body_last", 32'(observed.body_last), 32'(predicted.body_last));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        parse_byte(byte_ch.data_byte, byte_ch.tag_start, predicted);
        expected_results.insert(expected_results.size(), predicted);
        pending_bytes.delete(0);
        byte_taken = 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = '0;
    wr_data           = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.tag_start = 1'b0;
    res_ch.ready      = 1'b0;
    byte_taken        = 1'b0;
    steady_run        = 1'b0;
    gap_left          = 0;
    stall_left        = 0;
    mismatch_count    = 0;
    parse_phase       = id3_pkg::PH_TAG;
    hdr_pos           = '0;
    id_word           = '0;
    size_word         = '0;
    body_left         = '0;
    skip_body         = 1'b0;
    tag_size_q        = '0;
    tag_flags_q       = '0;
    frame_flags_q     = '0;
    kind_q            = '0;
    banned_a          = '0;
    banned_b          = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: first byte after reset without restart mark, max header fields
    queue_tag_header(1'b0, 8'hFF, 28'h0FFFFFFF);
    queue_frame_header("TXXX", 28'd0, 8'hFF, 8'hFF); // empty body
    queue_frame_header("TIT2", 28'd1, 8'h00, 8'h00);
    queue_byte(8'hFF, 1'b0);
    queue_frame_header("ab12", 28'd3, 8'h5A, 8'hA5); // bad id, padding follows
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte("I", 1'b1);                           // restart inside a tag header
    queue_byte("D", 1'b0);
    queue_byte("3", 1'b0);
    queue_tag_header(1'b1, 8'h00, 28'd0);
    queue_frame_header("COMM", 28'h0FFFFFFF, 8'h00, 8'h00);
    queue_body(2);
    wait_idle();

    // Banned ids: a listed one and one with bad characters
    configure_banned("COMM", "AB!?");
    while (pending_bytes.size() < 640) queue_random_tag();
    wait_idle();

    // All-ones and a text id in the banned registers
    configure_banned(32'hFFFFFFFF, "TIT2");
    while (pending_bytes.size() < 640) queue_random_tag();
    wait_idle();

    // Last stretch without idling on either side
    configure_banned("PRIV", 32'h0);
    steady_run = 1'b1;
    while (pending_bytes.size() < 640) queue_random_tag();
    wait_idle();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
